/* rtl/assert_macros.svh */
// ------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent assertions of the RTL modules.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(name, clk, rstn, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rstn, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* rtl/fat16fr_pkg.sv */
// ------------------------------------------------------------------------
// fat16fr_pkg
// Types, codes and constants shared by the FAT16 file read sequencer.
// ------------------------------------------------------------------------
`default_nettype none

package fat16fr_pkg;

    localparam int BLOCK_BYTES_DEFAULT = 32;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [12:0] BPS_RESET = 13'd512;
    localparam logic [7:0]  SPC_RESET = 8'd1;
    localparam logic [31:0] FDS_RESET = 32'd0;
    localparam logic [15:0] RSV_RESET = 16'd1;
    localparam logic [15:0] THR_RESET = 16'd65527;

    typedef enum logic [2:0] {
        CFG_BYTES_PER_SECTOR    = 3'd0,
        CFG_SECTORS_PER_CLUSTER = 3'd1,
        CFG_FIRST_DATA_SECTOR   = 3'd2,
        CFG_RESERVED_SECTORS    = 3'd3,
        CFG_CHAIN_END_THRESHOLD = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        FUNC_OPEN    = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_DELIVER = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        KIND_DATA = 3'd0,
        KIND_FAT  = 3'd1,
        KIND_EOF  = 3'd2,
        KIND_OK   = 3'd3,
        KIND_BUSY = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MUL_CLUSTER,
        ST_SUM_SECTOR,
        ST_MUL_SECTOR,
        ST_EMIT_DATA,
        ST_MUL_FAT,
        ST_EMIT_FAT
    } state_t;

    typedef enum logic [1:0] {
        MUL_CLUSTER,
        MUL_SECTOR,
        MUL_FAT
    } mul_sel_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_SHORT,
        EMIT_DATA,
        EMIT_FAT
    } emit_t;

    typedef struct packed {
        logic     capture;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     sum_en;
        emit_t    emit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic read_go;
        logic advance;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/fat16fr_dp.sv */
// ------------------------------------------------------------------------
// fat16fr_dp
// Datapath: configuration, file state, shared multiplier and result register.
// ------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fat16fr_dp #(
    parameter int BLOCK_BYTES = fat16fr_pkg::BLOCK_BYTES_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [fat16fr_pkg::CFG_INDEX_W-1:0] cfg_addr,
    input  wire logic [fat16fr_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire logic [63:0]                       s_tdata,
    input  wire logic [1:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [31:0]                            m_tdata,
    output logic [2:0]                             m_tuser,
    output logic                                   m_tlast,
    input  wire fat16fr_pkg::dp_cmd_t              cmd,
    output fat16fr_pkg::dp_status_t                status
);

    localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);

    // Configuration registers.
    logic [12:0] bps_reg;
    logic [7:0]  spc_reg;
    logic [31:0] fds_reg;
    logic [15:0] rsv_reg;
    logic [15:0] thr_reg;

    // File state.
    logic [15:0] cc_reg;
    logic [31:0] pos_reg;
    logic [7:0]  sic_reg;
    logic [11:0] off_reg;
    logic [31:0] size_reg;
    logic        awaiting_reg;

    // Captured input item.
    fat16fr_pkg::func_t func_reg;
    logic [15:0] start_reg;
    logic [31:0] flen_reg;
    logic [15:0] entry_reg;

    // Arithmetic intermediates.
    logic [31:0] mul_reg;
    logic [31:0] sec_reg;

    // Result register.
    logic              m_tvalid_reg;
    fat16fr_pkg::kind_t kind_reg;
    logic [26:0]       blk_reg;
    logic [4:0]        idx_reg;
    logic              last_reg;

    logic [31:0] mul_a;
    logic [12:0] mul_b;
    logic [44:0] mul_full;
    logic [31:0] data_addr;
    logic [31:0] fat_addr;
    logic [31:0] data_shift;
    logic [31:0] fat_shift;
    logic [31:0] fat_rem;
    logic [12:0] next_off;
    logic        off_wrap;
    logic [7:0]  sic_adv;
    logic        eof;
    fat16fr_pkg::kind_t short_kind;
    logic        do_open;
    logic        do_deliver;

    // Operand selection for the single shared multiplier.
    always_comb begin
        case (cmd.mul_sel)
            fat16fr_pkg::MUL_CLUSTER: begin
                mul_a = {16'd0, cc_reg} - 32'd2;
                mul_b = {5'd0, spc_reg};
            end
            fat16fr_pkg::MUL_SECTOR: begin
                mul_a = sec_reg;
                mul_b = bps_reg;
            end
            fat16fr_pkg::MUL_FAT: begin
                mul_a = {16'd0, rsv_reg};
                mul_b = bps_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full   = {13'd0, mul_a} * {32'd0, mul_b};
    assign data_addr  = mul_reg + {20'd0, off_reg};
    assign fat_addr   = mul_reg + {15'd0, cc_reg, 1'b0};
    assign data_shift = data_addr >> BLK_SHIFT;
    assign fat_shift  = fat_addr >> BLK_SHIFT;
    assign fat_rem    = fat_addr & (32'(BLOCK_BYTES) - 32'd1);

    assign next_off = {1'b0, off_reg} + 13'(BLOCK_BYTES);
    assign off_wrap = (next_off >= bps_reg) || next_off[12];
    assign sic_adv  = off_wrap ? (sic_reg + 8'd1) : sic_reg;

    assign eof = (cc_reg == 16'd0) || (pos_reg > size_reg);

    // Result of items that finish without address work.
    always_comb begin
        short_kind = fat16fr_pkg::KIND_BUSY;
        do_open    = 1'b0;
        do_deliver = 1'b0;
        case (func_reg)
            fat16fr_pkg::FUNC_OPEN: begin
                short_kind = fat16fr_pkg::KIND_OK;
                do_open    = 1'b1;
            end
            fat16fr_pkg::FUNC_DELIVER: begin
                if (awaiting_reg) begin
                    short_kind = fat16fr_pkg::KIND_OK;
                    do_deliver = 1'b1;
                end
            end
            fat16fr_pkg::FUNC_READ: begin
                if (!awaiting_reg && eof) begin
                    short_kind = fat16fr_pkg::KIND_EOF;
                end
            end
            default: begin
                short_kind = fat16fr_pkg::KIND_BUSY;
            end
        endcase
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign status.read_go  = (func_reg == fat16fr_pkg::FUNC_READ) && !awaiting_reg && !eof;
    assign status.advance  = sic_adv >= spc_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bps_reg <= fat16fr_pkg::BPS_RESET;
            spc_reg <= fat16fr_pkg::SPC_RESET;
            fds_reg <= fat16fr_pkg::FDS_RESET;
            rsv_reg <= fat16fr_pkg::RSV_RESET;
            thr_reg <= fat16fr_pkg::THR_RESET;
        end else if (cfg_wr_en) begin
            case (fat16fr_pkg::cfg_index_t'(cfg_addr))
                fat16fr_pkg::CFG_BYTES_PER_SECTOR:    bps_reg <= cfg_wr_data[12:0];
                fat16fr_pkg::CFG_SECTORS_PER_CLUSTER: spc_reg <= cfg_wr_data[7:0];
                fat16fr_pkg::CFG_FIRST_DATA_SECTOR:   fds_reg <= cfg_wr_data[31:0];
                fat16fr_pkg::CFG_RESERVED_SECTORS:    rsv_reg <= cfg_wr_data[15:0];
                fat16fr_pkg::CFG_CHAIN_END_THRESHOLD: thr_reg <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    // Input capture and arithmetic pipeline registers.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg  <= fat16fr_pkg::func_t'(s_tuser);
            start_reg <= s_tdata[15:0];
            flen_reg  <= s_tdata[47:16];
            entry_reg <= s_tdata[63:48];
        end
        if (cmd.mul_en) begin
            mul_reg <= mul_full[31:0];
        end
        if (cmd.sum_en) begin
            sec_reg <= mul_reg + fds_reg + {24'd0, sic_reg};
        end
    end

    // File state updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg       <= '0;
            pos_reg      <= '0;
            sic_reg      <= '0;
            off_reg      <= '0;
            size_reg     <= '0;
            awaiting_reg <= 1'b0;
        end else begin
            case (cmd.emit)
                fat16fr_pkg::EMIT_SHORT: begin
                    if (do_open) begin
                        cc_reg       <= start_reg;
                        size_reg     <= flen_reg;
                        pos_reg      <= '0;
                        sic_reg      <= '0;
                        off_reg      <= '0;
                        awaiting_reg <= 1'b0;
                    end else if (do_deliver) begin
                        cc_reg       <= (entry_reg > thr_reg) ? 16'd0 : entry_reg;
                        awaiting_reg <= 1'b0;
                    end
                end
                fat16fr_pkg::EMIT_DATA: begin
                    pos_reg <= pos_reg + 32'(BLOCK_BYTES);
                    off_reg <= off_wrap ? 12'd0 : next_off[11:0];
                    sic_reg <= status.advance ? 8'd0 : sic_adv;
                end
                fat16fr_pkg::EMIT_FAT: begin
                    awaiting_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Result register: loads when the controller emits, clears when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit != fat16fr_pkg::EMIT_NONE) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.emit)
            fat16fr_pkg::EMIT_SHORT: begin
                kind_reg <= short_kind;
                blk_reg  <= '0;
                idx_reg  <= '0;
                last_reg <= 1'b1;
            end
            fat16fr_pkg::EMIT_DATA: begin
                kind_reg <= fat16fr_pkg::KIND_DATA;
                blk_reg  <= data_shift[26:0];
                idx_reg  <= '0;
                last_reg <= !status.advance;
            end
            fat16fr_pkg::EMIT_FAT: begin
                kind_reg <= fat16fr_pkg::KIND_FAT;
                blk_reg  <= fat_shift[26:0];
                idx_reg  <= fat_rem[4:0];
                last_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {idx_reg, blk_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

    // A FAT request always leaves the block waiting for the entry.
    `ASSERT_NEXT(a_fat_sets_wait, aclk, aresetn, cmd.emit == fat16fr_pkg::EMIT_FAT, awaiting_reg)
    // A FAT request is only made for a live cluster.
    `ASSERT_IMPLY(a_fat_live_cluster, aclk, aresetn, cmd.emit == fat16fr_pkg::EMIT_FAT, cc_reg != 16'd0)
    // A data result is the last one exactly when the cluster is not used up.
    `ASSERT_NEXT(a_data_last, aclk, aresetn, cmd.emit == fat16fr_pkg::EMIT_DATA, m_tlast == !$past(status.advance))

endmodule

`default_nettype wire

/* rtl/fat16fr_ctrl.sv */
// ------------------------------------------------------------------------
// fat16fr_ctrl
// Controller: sequences capture, multiplies and result emission.
// ------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fat16fr_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire fat16fr_pkg::dp_status_t status,
    output fat16fr_pkg::dp_cmd_t        cmd
);

    fat16fr_pkg::state_t state_reg;
    fat16fr_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fat16fr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.mul_en  = 1'b0;
        cmd.mul_sel = fat16fr_pkg::MUL_CLUSTER;
        cmd.sum_en  = 1'b0;
        cmd.emit    = fat16fr_pkg::EMIT_NONE;
        case (state_reg)
            fat16fr_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = fat16fr_pkg::ST_DISPATCH;
                end
            end
            fat16fr_pkg::ST_DISPATCH: begin
                if (status.read_go) begin
                    state_next = fat16fr_pkg::ST_MUL_CLUSTER;
                end else if (status.out_free) begin
                    cmd.emit   = fat16fr_pkg::EMIT_SHORT;
                    state_next = fat16fr_pkg::ST_IDLE;
                end
            end
            fat16fr_pkg::ST_MUL_CLUSTER: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = fat16fr_pkg::MUL_CLUSTER;
                state_next  = fat16fr_pkg::ST_SUM_SECTOR;
            end
            fat16fr_pkg::ST_SUM_SECTOR: begin
                cmd.sum_en = 1'b1;
                state_next = fat16fr_pkg::ST_MUL_SECTOR;
            end
            fat16fr_pkg::ST_MUL_SECTOR: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = fat16fr_pkg::MUL_SECTOR;
                state_next  = fat16fr_pkg::ST_EMIT_DATA;
            end
            fat16fr_pkg::ST_EMIT_DATA: begin
                if (status.out_free) begin
                    cmd.emit   = fat16fr_pkg::EMIT_DATA;
                    state_next = status.advance ? fat16fr_pkg::ST_MUL_FAT
                                                : fat16fr_pkg::ST_IDLE;
                end
            end
            fat16fr_pkg::ST_MUL_FAT: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = fat16fr_pkg::MUL_FAT;
                state_next  = fat16fr_pkg::ST_EMIT_FAT;
            end
            fat16fr_pkg::ST_EMIT_FAT: begin
                if (status.out_free) begin
                    cmd.emit   = fat16fr_pkg::EMIT_FAT;
                    state_next = fat16fr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fat16fr_pkg::ST_IDLE;
            end
        endcase
    end

    // Every captured item is classified in the following cycle.
    `ASSERT_NEXT(a_capture_dispatch, aclk, aresetn, cmd.capture, state_reg == fat16fr_pkg::ST_DISPATCH)
    // The FAT address multiply is always followed by the FAT result.
    `ASSERT_NEXT(a_fat_follows, aclk, aresetn, state_reg == fat16fr_pkg::ST_MUL_FAT, state_reg == fat16fr_pkg::ST_EMIT_FAT)
    // A data result is never dropped while the result register is occupied.
    `ASSERT_NEXT(a_data_waits, aclk, aresetn, state_reg == fat16fr_pkg::ST_EMIT_DATA && !status.out_free, state_reg == fat16fr_pkg::ST_EMIT_DATA)

endmodule

`default_nettype wire

/* rtl/fat16_file_read_sequencer.sv */
// ------------------------------------------------------------------------
// fat16_file_read_sequencer
// Results: open, deliver, not-ready and end-of-file results are loaded from
// the dispatch state; a data request first passes the cluster multiply, sector
// sum and sector multiply states, and the FAT request that may follow it the
// FAT multiply state; an output stall holds any result. A new item is taken
// only once the last one is done; the shared multiplier is used up to three times.
// Reset: synchronous active-low; clears the file state, loads the register
// defaults, and the block is ready in the first cycle after it.
// ------------------------------------------------------------------------
`default_nettype none

module fat16_file_read_sequencer #(
    parameter int BLOCK_BYTES = fat16fr_pkg::BLOCK_BYTES_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration write port. Index 0 bytes_per_sector, 1 sectors_per_cluster,
    // 2 first_data_sector, 3 reserved_sectors, 4 chain_end_threshold.
    input  wire logic                                cfg_wr_en,
    input  wire logic [fat16fr_pkg::CFG_INDEX_W-1:0] cfg_addr,
    input  wire logic [fat16fr_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // Input items.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [63:0]                         s_tdata,  // start_cluster[15:0],
                                                               // file_length[47:16],
                                                               // fat_entry[63:48]
    input  wire logic [1:0]                          s_tuser,  // func[1:0]
    // Result items.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [31:0]                              m_tdata,  // block_address[26:0],
                                                               // byte_index[31:27]
    output logic [2:0]                               m_tuser,  // kind[2:0]
    output logic                                     m_tlast   // last result of the item
);

    // The controller and datapath talk only through these two bundles.
    // The command bundle tells the datapath when to capture an input transfer,
    // which product the shared multiplier forms, when to build the sector
    // number and which result to load into the output register.
    fat16fr_pkg::dp_cmd_t    cmd;
    // The status bundle reports whether the output register can take a new
    // result, whether a read item goes on to address work (file open, no FAT
    // entry pending, not at end of file) and whether the data block being
    // emitted uses up the current cluster.
    fat16fr_pkg::dp_status_t status;

    // The controller accepts a new item whenever it is idle, even while the
    // previous result still waits in the output register for m_tready.
    fat16fr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the configuration, the open file's cluster, position,
    // sector and offset, and forms the data address as
    // ((cluster - 2) * sectors_per_cluster + first_data_sector + sector)
    // * bytes_per_sector + offset, and the FAT entry address as
    // reserved_sectors * bytes_per_sector + 2 * cluster, all modulo 2^32.
    fat16fr_dp #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

`default_nettype wire
